/* src/bam_pkg.sv */
`default_nettype none

package bam_pkg;

    localparam int LEVEL_W  = 14;
    localparam int TEMP_W   = 12;
    localparam int VOLT_W   = 16;
    localparam int ENERGY_W = 24;
    localparam int TIME_W   = 32;
    localparam int HEALTH_W = 16;
    localparam int RATE_W   = 27;
    localparam int CFG_W    = 14;
    localparam int CFG_IDX_W = 2;

    localparam int S_TDATA_W = 128;
    localparam int M_TDATA_W = 136;

    localparam int SCALE_W = 14;
    localparam logic [SCALE_W-1:0] HEALTH_SCALE = 14'd10000;
    localparam logic [SCALE_W-1:0] RATE_SCALE   = 14'd3600;

    localparam int HPROD_W = ENERGY_W + SCALE_W;
    localparam int HQUO_W  = HEALTH_W;
    localparam int RPROD_W = 26;
    localparam int RNUM_W  = 29;
    localparam int RQUO_W  = 26;

    localparam logic [RQUO_W-1:0] RATE_MAX    = 26'd36000000;
    localparam logic [TIME_W-1:0] AVG_DIVISOR = 32'd10;

    localparam logic signed [TEMP_W-1:0] TEMP_FLOOR = -12'sd1000;

    localparam logic [CFG_W-1:0]         CRIT_LEVEL_RST = 14'd500;
    localparam logic [CFG_W-1:0]         LOW_LEVEL_RST  = 14'd2000;
    localparam logic signed [TEMP_W-1:0] HIGH_TEMP_RST  = 12'sd600;
    localparam logic [CFG_W-1:0]         LOW_HEALTH_RST = 14'd6000;

    typedef enum logic [1:0] {
        LVL_NONE = 2'd0,
        LVL_LOW  = 2'd1,
        LVL_CRIT = 2'd2
    } lvl_alert_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CRIT_LEVEL = 2'd0,
        REG_LOW_LEVEL  = 2'd1,
        REG_HIGH_TEMP  = 2'd2,
        REG_LOW_HEALTH = 2'd3
    } reg_idx_t;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_MUL    = 7'b0000010,
        ST_DSTART = 7'b0000100,
        ST_DWAIT  = 7'b0001000,
        ST_ASTART = 7'b0010000,
        ST_AWAIT  = 7'b0100000,
        ST_DONE   = 7'b1000000
    } state_t;

endpackage

`default_nettype wire

/* src/bam_sdiv.sv */
`default_nettype none

module bam_sdiv #(
    parameter int NUM_W = 38,
    parameter int DEN_W = 24,
    parameter int QUO_W = 16
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic                  busy,
    output logic [QUO_W-1:0]      quo
);

    localparam int CNT_W = $clog2(QUO_W + 1);

    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [QUO_W-1:0] shf_reg, shf_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   trial_sub;
    logic             fits;

    assign trial     = {rem_reg, shf_reg[QUO_W-1]};
    assign trial_sub = trial - {1'b0, den_reg};
    assign fits      = trial >= {1'b0, den_reg};
    assign busy      = cnt_reg != '0;
    assign quo       = shf_reg;

    always_comb begin
        rem_next = rem_reg;
        den_next = den_reg;
        shf_next = shf_reg;
        cnt_next = cnt_reg;
        if (start) begin
            rem_next = DEN_W'(num[NUM_W-1:QUO_W]);
            den_next = den;
            shf_next = num[QUO_W-1:0];
            cnt_next = CNT_W'(QUO_W);
        end else if (busy) begin
            rem_next = fits ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
            shf_next = {shf_reg[QUO_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        shf_reg <= shf_next;
    end

endmodule

`default_nettype wire

/* src/battery_alert_and_stats_monitor.sv */
`default_nettype none

// Battery sample monitor. Each transfer on the s_ side carries one sample and
// yields exactly one result on the m_ side. A present sample passes through the
// bit-serial constant multipliers (14 steps), then the 26-step rate divider,
// which runs once for the instant rate and, when the discharge average is
// updated from an earlier value, once more for the division by ten of the
// average, and the 16-step health divider running beside it; a sample without
// a battery goes straight to the output register. One sample is in work at a
// time; the next one is taken while the previous result still waits in the
// output register. Thresholds are written through the cfg_ port; the user must
// write them only while the block is idle, which the block does not enforce.
module battery_alert_and_stats_monitor (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // charging, level, temperature, voltage_mv, energy_full, energy_design, time_s
    input  wire logic [bam_pkg::S_TDATA_W-1:0]   s_tdata,
    // present
    input  wire logic [0:0]                      s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // level_alert, temp_alert, health_alert, health, min_level, max_level,
    // min_temp, max_temp, min_voltage, max_voltage, discharge_rate
    output logic [bam_pkg::M_TDATA_W-1:0]        m_tdata,
    // accepted
    output logic [0:0]                           m_tuser,
    input  wire logic                            cfg_wr_en,
    input  wire logic [bam_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [bam_pkg::CFG_W-1:0]       cfg_wdata
);

    import bam_pkg::*;

    localparam int MCNT_W = $clog2(SCALE_W);
    localparam int PAD_W  = M_TDATA_W - (2 + 1 + 1 + HEALTH_W + 2 * LEVEL_W + 2 * TEMP_W
                                         + 2 * VOLT_W + RATE_W);

    logic                       in_present;
    logic                       in_charging;
    logic [LEVEL_W-1:0]         in_level;
    logic signed [TEMP_W-1:0]   in_temp;
    logic [VOLT_W-1:0]          in_volt;
    logic [ENERGY_W-1:0]        in_efull;
    logic [ENERGY_W-1:0]        in_edes;
    logic [TIME_W-1:0]          in_time;
    logic                       in_xfer;

    assign in_present  = s_tuser[0];
    assign in_charging = s_tdata[0];
    assign in_level    = s_tdata[14:1];
    assign in_temp     = s_tdata[26:15];
    assign in_volt     = s_tdata[42:27];
    assign in_efull    = s_tdata[66:43];
    assign in_edes     = s_tdata[90:67];
    assign in_time     = s_tdata[122:91];

    state_t                     state_reg, state_next;
    logic [CFG_W-1:0]           crit_level_reg, crit_level_next;
    logic [CFG_W-1:0]           low_level_reg, low_level_next;
    logic signed [TEMP_W-1:0]   high_temp_reg, high_temp_next;
    logic [CFG_W-1:0]           low_health_reg, low_health_next;

    logic [LEVEL_W-1:0]         least_level_reg, least_level_next;
    logic [LEVEL_W-1:0]         most_level_reg, most_level_next;
    logic signed [TEMP_W-1:0]   least_temp_reg, least_temp_next;
    logic signed [TEMP_W-1:0]   most_temp_reg, most_temp_next;
    logic [VOLT_W-1:0]          least_volt_reg, least_volt_next;
    logic [VOLT_W-1:0]          most_volt_reg, most_volt_next;
    logic [RATE_W-1:0]          avg_reg, avg_next;
    logic [LEVEL_W-1:0]         prev_level_reg, prev_level_next;
    logic [TIME_W-1:0]          prev_time_reg, prev_time_next;
    logic                       prev_valid_reg, prev_valid_next;
    logic                       m_tvalid_reg, m_tvalid_next;

    logic [MCNT_W-1:0]          mul_cnt_reg, mul_cnt_next;
    logic [HPROD_W-1:0]         hacc_reg, hacc_next;
    logic [RPROD_W-1:0]         racc_reg, racc_next;
    logic [ENERGY_W-1:0]        efull_reg, efull_next;
    logic [ENERGY_W-1:0]        edes_reg, edes_next;
    logic [LEVEL_W-1:0]         diff_reg, diff_next;
    logic [TIME_W-1:0]          dt_reg, dt_next;
    logic                       rate_en_reg, rate_en_next;
    logic                       present_reg, present_next;
    lvl_alert_t                 lvl_alert_reg, lvl_alert_next;
    logic                       temp_alert_reg, temp_alert_next;
    logic                       health_alert_reg, health_alert_next;
    logic [HEALTH_W-1:0]        health_reg, health_next;
    logic [M_TDATA_W-1:0]       m_tdata_reg, m_tdata_next;
    logic                       m_tuser_reg, m_tuser_next;

    logic                       h_start;
    logic                       h_busy;
    logic [HQUO_W-1:0]          h_quo;
    logic                       r_start;
    logic                       r_busy;
    logic [RQUO_W-1:0]          r_quo;
    logic [RNUM_W-1:0]          r_num;
    logic [TIME_W-1:0]          r_den;

    logic [HEALTH_W-1:0]        health_val;
    logic [RQUO_W-1:0]          rate_sat;
    logic [RQUO_W-1:0]          avg_mag;

    assign s_tready = state_reg == ST_IDLE;
    assign in_xfer  = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    assign rate_sat = (r_quo > RATE_MAX) ? RATE_MAX : r_quo;
    assign avg_mag  = avg_reg[RQUO_W-1:0];

    always_comb begin
        if (edes_reg == '0) begin
            health_val = '0;
        end else if ({2'b00, hacc_reg[HPROD_W-1:HQUO_W]} >= edes_reg) begin
            health_val = '1;
        end else begin
            health_val = h_quo;
        end
    end

    always_comb begin
        crit_level_next = crit_level_reg;
        low_level_next  = low_level_reg;
        high_temp_next  = high_temp_reg;
        low_health_next = low_health_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_CRIT_LEVEL: crit_level_next = cfg_wdata;
                REG_LOW_LEVEL:  low_level_next  = cfg_wdata;
                REG_HIGH_TEMP:  high_temp_next  = cfg_wdata[TEMP_W-1:0];
                REG_LOW_HEALTH: low_health_next = cfg_wdata;
            endcase
        end
    end

    always_comb begin
        state_next        = state_reg;
        least_level_next  = least_level_reg;
        most_level_next   = most_level_reg;
        least_temp_next   = least_temp_reg;
        most_temp_next    = most_temp_reg;
        least_volt_next   = least_volt_reg;
        most_volt_next    = most_volt_reg;
        avg_next          = avg_reg;
        prev_level_next   = prev_level_reg;
        prev_time_next    = prev_time_reg;
        prev_valid_next   = prev_valid_reg;
        mul_cnt_next      = mul_cnt_reg;
        hacc_next         = hacc_reg;
        racc_next         = racc_reg;
        efull_next        = efull_reg;
        edes_next         = edes_reg;
        diff_next         = diff_reg;
        dt_next           = dt_reg;
        rate_en_next      = rate_en_reg;
        present_next      = present_reg;
        lvl_alert_next    = lvl_alert_reg;
        temp_alert_next   = temp_alert_reg;
        health_alert_next = health_alert_reg;
        health_next       = health_reg;
        m_tdata_next      = m_tdata_reg;
        m_tuser_next      = m_tuser_reg;
        m_tvalid_next     = m_tvalid_reg;
        h_start           = 1'b0;
        r_start           = 1'b0;
        r_num             = RNUM_W'(racc_reg);
        r_den             = dt_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    present_next      = in_present;
                    lvl_alert_next    = LVL_NONE;
                    temp_alert_next   = 1'b0;
                    health_alert_next = 1'b0;
                    health_next       = '0;
                    if (in_present) begin
                        if (in_level <= crit_level_reg) begin
                            lvl_alert_next = LVL_CRIT;
                        end else if (in_level <= low_level_reg) begin
                            lvl_alert_next = LVL_LOW;
                        end
                        temp_alert_next = in_temp >= high_temp_reg;
                        if (in_level < least_level_reg) begin
                            least_level_next = in_level;
                        end
                        if (in_level > most_level_reg) begin
                            most_level_next = in_level;
                        end
                        if (in_temp > TEMP_FLOOR) begin
                            if (in_temp < least_temp_reg) begin
                                least_temp_next = in_temp;
                            end
                            if (in_temp > most_temp_reg) begin
                                most_temp_next = in_temp;
                            end
                        end
                        if (in_volt != '0) begin
                            if (in_volt < least_volt_reg) begin
                                least_volt_next = in_volt;
                            end
                            if (in_volt > most_volt_reg) begin
                                most_volt_next = in_volt;
                            end
                        end
                        rate_en_next = prev_valid_reg && !in_charging
                                       && (prev_level_reg > in_level)
                                       && (in_time > prev_time_reg);
                        diff_next       = prev_level_reg - in_level;
                        dt_next         = in_time - prev_time_reg;
                        prev_level_next = in_level;
                        prev_time_next  = in_time;
                        prev_valid_next = 1'b1;
                        efull_next      = in_efull;
                        edes_next       = in_edes;
                        hacc_next       = '0;
                        racc_next       = '0;
                        mul_cnt_next    = MCNT_W'(SCALE_W - 1);
                        state_next      = ST_MUL;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_MUL: begin
                hacc_next = {hacc_reg[HPROD_W-2:0], 1'b0}
                            + (HEALTH_SCALE[mul_cnt_reg] ? HPROD_W'(efull_reg) : '0);
                racc_next = {racc_reg[RPROD_W-2:0], 1'b0}
                            + (RATE_SCALE[mul_cnt_reg] ? RPROD_W'(diff_reg) : '0);
                if (mul_cnt_reg == '0) begin
                    state_next = ST_DSTART;
                end else begin
                    mul_cnt_next = mul_cnt_reg - 1'b1;
                end
            end
            ST_DSTART: begin
                h_start    = 1'b1;
                r_start    = 1'b1;
                state_next = ST_DWAIT;
            end
            ST_DWAIT: begin
                if (!h_busy && !r_busy) begin
                    health_next       = health_val;
                    health_alert_next = health_val <= HEALTH_W'(low_health_reg);
                    state_next        = ST_ASTART;
                end
            end
            ST_ASTART: begin
                r_num = {avg_mag, 3'b000} + RNUM_W'(avg_mag) + RNUM_W'(rate_sat);
                r_den = AVG_DIVISOR;
                if (!rate_en_reg) begin
                    state_next = ST_DONE;
                end else if (avg_reg[RATE_W-1]) begin
                    avg_next   = RATE_W'(rate_sat);
                    state_next = ST_DONE;
                end else begin
                    r_start    = 1'b1;
                    state_next = ST_AWAIT;
                end
            end
            ST_AWAIT: begin
                if (!r_busy) begin
                    avg_next   = RATE_W'(r_quo);
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = present_reg;
                    m_tdata_next  = {{PAD_W{1'b0}}, avg_reg,
                                     most_volt_reg, least_volt_reg,
                                     most_temp_reg, least_temp_reg,
                                     most_level_reg, least_level_reg,
                                     health_reg, health_alert_reg, temp_alert_reg,
                                     lvl_alert_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            crit_level_reg  <= CRIT_LEVEL_RST;
            low_level_reg   <= LOW_LEVEL_RST;
            high_temp_reg   <= HIGH_TEMP_RST;
            low_health_reg  <= LOW_HEALTH_RST;
            least_level_reg <= '1;
            most_level_reg  <= '0;
            least_temp_reg  <= {1'b0, {(TEMP_W-1){1'b1}}};
            most_temp_reg   <= {1'b1, {(TEMP_W-1){1'b0}}};
            least_volt_reg  <= '1;
            most_volt_reg   <= '0;
            avg_reg         <= '1;
            prev_level_reg  <= '0;
            prev_time_reg   <= '0;
            prev_valid_reg  <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg       <= state_next;
            crit_level_reg  <= crit_level_next;
            low_level_reg   <= low_level_next;
            high_temp_reg   <= high_temp_next;
            low_health_reg  <= low_health_next;
            least_level_reg <= least_level_next;
            most_level_reg  <= most_level_next;
            least_temp_reg  <= least_temp_next;
            most_temp_reg   <= most_temp_next;
            least_volt_reg  <= least_volt_next;
            most_volt_reg   <= most_volt_next;
            avg_reg         <= avg_next;
            prev_level_reg  <= prev_level_next;
            prev_time_reg   <= prev_time_next;
            prev_valid_reg  <= prev_valid_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mul_cnt_reg      <= mul_cnt_next;
        hacc_reg         <= hacc_next;
        racc_reg         <= racc_next;
        efull_reg        <= efull_next;
        edes_reg         <= edes_next;
        diff_reg         <= diff_next;
        dt_reg           <= dt_next;
        rate_en_reg      <= rate_en_next;
        present_reg      <= present_next;
        lvl_alert_reg    <= lvl_alert_next;
        temp_alert_reg   <= temp_alert_next;
        health_alert_reg <= health_alert_next;
        health_reg       <= health_next;
        m_tdata_reg      <= m_tdata_next;
        m_tuser_reg      <= m_tuser_next;
    end

    bam_sdiv #(
        .NUM_W (HPROD_W),
        .DEN_W (ENERGY_W),
        .QUO_W (HQUO_W)
    ) u_health_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (h_start),
        .num     (hacc_reg),
        .den     (edes_reg),
        .busy    (h_busy),
        .quo     (h_quo)
    );

    bam_sdiv #(
        .NUM_W (RNUM_W),
        .DEN_W (TIME_W),
        .QUO_W (RQUO_W)
    ) u_rate_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (r_start),
        .num     (r_num),
        .den     (r_den),
        .busy    (r_busy),
        .quo     (r_quo)
    );

endmodule

`default_nettype wire
